// ----- rtl/ttf_pkg.sv -----
package ttf_pkg;

    // Default width of the position, normal, texture and tangent fields.
    localparam int VALUE_WIDTH_DEF = 16;

    // Width of the configuration register.
    localparam int CFG_W = 16;

    // Normals and emitted tangents are Q1.14 held in 16 bits.
    localparam int NORM_W  = 16;
    localparam int ONE_Q14 = 16384;

    // Scaled tangent and bitangent: magnitude below 2^24.
    localparam int SB_W  = 25;
    localparam int SB_HI = 24;
    localparam int SB_LO = 22;

    // Projected tangent is scaled down until its magnitude is below 2^30.
    localparam int T_HI = 30;

    // Coarse step of the block scaling unit.
    localparam int COARSE = 8;

    // Shared multiplier and accumulator.
    localparam int MUL_W = 32;
    localparam int ACC_W = 64;

    // Dot product of the normal with the scaled tangent, and its split.
    localparam int DOT_W   = 42;
    localparam int D_SPLIT = 20;
    localparam int T_SHIFT = 28;

    // Cross product terms.
    localparam int CROSS_W = 32;

    // Square root: first trial bit of a 64-bit radicand.
    localparam int SQRT_TOP = 62;
    localparam int LEN_W    = 32;

    // Division: numerator width and quotient bits.
    localparam int NUM_W  = 48;
    localparam int QUOT_W = 16;
    localparam int Q_SHIFT = 15;

    // Entries of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Width of one triangle record: ten differences and nine normal components.
    function automatic int rec_width(input int vw);
        return 10 * (vw + 1) + 9 * NORM_W;
    endfunction

endpackage

// ----- rtl/ttf_front.sv -----
module ttf_front
    import ttf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [VALUE_WIDTH-1:0]        pos_x,
    input  logic signed [VALUE_WIDTH-1:0]        pos_y,
    input  logic signed [VALUE_WIDTH-1:0]        pos_z,
    input  logic signed [VALUE_WIDTH-1:0]        norm_x,
    input  logic signed [VALUE_WIDTH-1:0]        norm_y,
    input  logic signed [VALUE_WIDTH-1:0]        norm_z,
    input  logic signed [VALUE_WIDTH-1:0]        tex_u,
    input  logic signed [VALUE_WIDTH-1:0]        tex_v,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [rec_width(VALUE_WIDTH)-1:0]    q_data
);

    localparam int D_W = VALUE_WIDTH + 1;
    localparam int CW  = (VALUE_WIDTH > NORM_W) ? VALUE_WIDTH : NORM_W;
    localparam logic signed [CW-1:0] N_MAX = CW'(ONE_Q14);
    localparam logic signed [CW-1:0] N_MIN = CW'(-ONE_Q14);
    localparam logic [1:0] CC_THIRD = 2'd2;

    logic [1:0]                    cc_reg;
    logic signed [VALUE_WIDTH-1:0] hp_reg [2][3];
    logic signed [NORM_W-1:0]      hn_reg [2][3];
    logic signed [VALUE_WIDTH-1:0] ht_reg [2][2];

    logic signed [VALUE_WIDTH-1:0] p_in [3];
    logic signed [VALUE_WIDTH-1:0] n_in [3];
    logic signed [NORM_W-1:0]      nc [3];
    logic signed [D_W-1:0]         e1 [3];
    logic signed [D_W-1:0]         e2 [3];
    logic signed [D_W-1:0]         du1, dv1, du2, dv2;
    logic                          accept;

    assign p_in[0] = pos_x;
    assign p_in[1] = pos_y;
    assign p_in[2] = pos_z;
    assign n_in[0] = norm_x;
    assign n_in[1] = norm_y;
    assign n_in[2] = norm_z;

    // The third corner waits for room in the queue; the first two are always taken.
    assign in_ready = (cc_reg != CC_THIRD) || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (cc_reg == CC_THIRD);

    // Saturate each normal component to the unit range.
    always_comb
    begin
        logic signed [CW-1:0] nx;
        for (int i = 0; i < 3; i++)
        begin
            nx = CW'(n_in[i]);
            if (nx > N_MAX)
            begin
                nc[i] = NORM_W'(N_MAX);
            end
            else if (nx < N_MIN)
            begin
                nc[i] = NORM_W'(N_MIN);
            end
            else
            begin
                nc[i] = NORM_W'(nx);
            end
        end
    end

    // Edge and texture differences against the first corner.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = D_W'(hp_reg[1][i]) - D_W'(hp_reg[0][i]);
            e2[i] = D_W'(p_in[i]) - D_W'(hp_reg[0][i]);
        end
        du1 = D_W'(ht_reg[1][0]) - D_W'(ht_reg[0][0]);
        dv1 = D_W'(ht_reg[1][1]) - D_W'(ht_reg[0][1]);
        du2 = D_W'(tex_u) - D_W'(ht_reg[0][0]);
        dv2 = D_W'(tex_v) - D_W'(ht_reg[0][1]);
    end

    // Pack the triangle record.
    always_comb
    begin
        q_data = '0;
        for (int i = 0; i < 3; i++)
        begin
            q_data[i * D_W +: D_W]       = e1[i];
            q_data[(3 + i) * D_W +: D_W] = e2[i];
            q_data[10 * D_W + i * NORM_W +: NORM_W]       = hn_reg[0][i];
            q_data[10 * D_W + (3 + i) * NORM_W +: NORM_W] = hn_reg[1][i];
            q_data[10 * D_W + (6 + i) * NORM_W +: NORM_W] = nc[i];
        end
        q_data[6 * D_W +: D_W] = du1;
        q_data[7 * D_W +: D_W] = dv1;
        q_data[8 * D_W +: D_W] = du2;
        q_data[9 * D_W +: D_W] = dv2;
    end

    // Corner counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
        end
        else if (accept)
        begin
            cc_reg <= (cc_reg == CC_THIRD) ? 2'd0 : cc_reg + 2'd1;
        end
    end

    // Hold the first two corners.
    always_ff @(posedge clk)
    begin
        if (accept && (cc_reg != CC_THIRD))
        begin
            for (int i = 0; i < 3; i++)
            begin
                hp_reg[cc_reg[0]][i] <= p_in[i];
                hn_reg[cc_reg[0]][i] <= nc[i];
            end
            ht_reg[cc_reg[0]][0] <= tex_u;
            ht_reg[cc_reg[0]][1] <= tex_v;
        end
    end

endmodule

// ----- rtl/ttf_queue.sv -----
module ttf_queue
    import ttf_pkg::*;
#(
    parameter int WIDTH = rec_width(VALUE_WIDTH_DEF)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_reg];

    // Pointers and fill count; the depth is a power of two so pointers wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/ttf_back.sv -----
module ttf_back
    import ttf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [CFG_W-1:0]                     min_uv_area,
    input  logic                                 q_valid,
    input  logic [rec_width(VALUE_WIDTH)-1:0]    q_data,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [VALUE_WIDTH-1:0]        tan_x,
    output logic signed [VALUE_WIDTH-1:0]        tan_y,
    output logic signed [VALUE_WIDTH-1:0]        tan_z,
    output logic                                 mirrored,
    output logic                                 last_corner
);

    localparam int D_W  = VALUE_WIDTH + 1;
    localparam int DH_W = DOT_W - D_SPLIT;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DET   = 4'd1;
    localparam logic [3:0] ST_SIGN  = 4'd2;
    localparam logic [3:0] ST_SB    = 4'd3;
    localparam logic [3:0] ST_NORM  = 4'd4;
    localparam logic [3:0] ST_DOT   = 4'd5;
    localparam logic [3:0] ST_TVEC  = 4'd6;
    localparam logic [3:0] ST_TCHK  = 4'd7;
    localparam logic [3:0] ST_LEN   = 4'd8;
    localparam logic [3:0] ST_SQRT  = 4'd9;
    localparam logic [3:0] ST_DINIT = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_CROSS = 4'd12;
    localparam logic [3:0] ST_HAND  = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    localparam logic [1:0] NS_S = 2'd0;
    localparam logic [1:0] NS_B = 2'd1;
    localparam logic [1:0] NS_T = 2'd2;

    localparam logic [1:0] K_LAST = 2'd2;
    localparam logic [2:0] J_PAIR_LAST = 3'd5;
    localparam logic [2:0] J_TRI_LAST  = 3'd2;
    localparam logic [2:0] J_DET_LAST  = 3'd1;

    localparam logic [QUOT_W-1:0] Q_MAX = QUOT_W'(ONE_Q14);

    // Unpacked triangle record.
    logic signed [D_W-1:0]    e1 [3];
    logic signed [D_W-1:0]    e2 [3];
    logic signed [D_W-1:0]    du1, dv1, du2, dv2;
    logic signed [NORM_W-1:0] nv [3][3];
    logic signed [NORM_W-1:0] nk [3];

    // Control.
    logic [3:0] st_reg;
    logic       ph_reg;
    logic [2:0] j_reg;
    logic [1:0] k_reg;
    logic [1:0] i_reg;
    logic [1:0] nsel_reg;
    logic [3:0] dcnt_reg;
    logic       out_valid_reg;

    // Data path registers.
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      sg_zero_reg;
    logic                      sg_neg_reg;
    logic signed [ACC_W-1:0]   w_reg [3];
    logic signed [SB_W-1:0]    s_reg [3];
    logic signed [SB_W-1:0]    b_reg [3];
    logic signed [DOT_W-1:0]   d_reg;
    logic [ACC_W-1:0]          x_reg;
    logic [ACC_W-1:0]          r_reg;
    logic [ACC_W-1:0]          bit_reg;
    logic [LEN_W-1:0]          l_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          dsh_reg;
    logic [QUOT_W-1:0]         q_reg;
    logic signed [NORM_W-1:0]  tq_reg [3];
    logic signed [CROSS_W-1:0] c_reg [3];
    logic                      mir_reg;
    logic signed [VALUE_WIDTH-1:0] tan_reg [3];
    logic                      last_reg;

    // Combinational helpers.
    logic signed [MUL_W-1:0] ma, mb;
    logic signed [ACC_W-1:0] base, sp, acc_next;
    logic                    sub, shf;
    logic [1:0]              ji;
    logic signed [DH_W-1:0]  dh;
    logic signed [D_SPLIT:0] dl;
    logic [ACC_W-1:0]        wm [3];
    logic [ACC_W-1:0]        mx;
    logic                    up, big1, big8, small1, small8, norm_done;
    logic signed [ACC_W-1:0] wn [3];
    logic [ACC_W-1:0]        rb;
    logic                    sq_ge;
    logic [NUM_W:0]          trial;
    logic                    dv_ge;
    logic [QUOT_W-1:0]       q_next, qc;
    logic signed [NORM_W-1:0] tq_next;
    logic                    out_free;
    logic                    det_small;

    // Record fields.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = q_data[i * D_W +: D_W];
            e2[i] = q_data[(3 + i) * D_W +: D_W];
            for (int k = 0; k < 3; k++)
            begin
                nv[k][i] = q_data[10 * D_W + (3 * k + i) * NORM_W +: NORM_W];
            end
        end
        du1 = q_data[6 * D_W +: D_W];
        dv1 = q_data[7 * D_W +: D_W];
        du2 = q_data[8 * D_W +: D_W];
        dv2 = q_data[9 * D_W +: D_W];
    end

    // Normal of the corner being worked on.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (k_reg)
                2'd0:    nk[i] = nv[0][i];
                2'd1:    nk[i] = nv[1][i];
                default: nk[i] = nv[2][i];
            endcase
        end
    end

    assign ji = j_reg[2:1];
    assign dh = d_reg[DOT_W-1:D_SPLIT];
    assign dl = {1'b0, d_reg[D_SPLIT-1:0]};

    // Operand selection for the shared multiplier and the accumulate step.
    always_comb
    begin
        ma   = '0;
        mb   = '0;
        base = acc_reg;
        sub  = 1'b0;
        shf  = 1'b0;
        case (st_reg)
            ST_DET:
            begin
                if (!j_reg[0])
                begin
                    ma   = MUL_W'(du1);
                    mb   = MUL_W'(dv2);
                    base = '0;
                end
                else
                begin
                    ma  = MUL_W'(du2);
                    mb  = MUL_W'(dv1);
                    sub = 1'b1;
                end
            end
            ST_SB:
            begin
                if (!j_reg[0])
                begin
                    ma   = (nsel_reg == NS_S) ? MUL_W'(dv2) : MUL_W'(du1);
                    mb   = (nsel_reg == NS_S) ? MUL_W'(e1[ji]) : MUL_W'(e2[ji]);
                    base = '0;
                    sub  = sg_neg_reg;
                end
                else
                begin
                    ma  = (nsel_reg == NS_S) ? MUL_W'(dv1) : MUL_W'(du2);
                    mb  = (nsel_reg == NS_S) ? MUL_W'(e2[ji]) : MUL_W'(e1[ji]);
                    sub = !sg_neg_reg;
                end
            end
            ST_DOT:
            begin
                ma   = MUL_W'(nk[j_reg[1:0]]);
                mb   = MUL_W'(s_reg[j_reg[1:0]]);
                base = (j_reg == '0) ? '0 : acc_reg;
            end
            ST_TVEC:
            begin
                ma  = MUL_W'(nk[ji]);
                sub = 1'b1;
                if (!j_reg[0])
                begin
                    mb   = MUL_W'(dh);
                    base = ACC_W'(s_reg[ji]) <<< T_SHIFT;
                    shf  = 1'b1;
                end
                else
                begin
                    mb = MUL_W'(dl);
                end
            end
            ST_LEN:
            begin
                ma   = w_reg[j_reg[1:0]][MUL_W-1:0];
                mb   = w_reg[j_reg[1:0]][MUL_W-1:0];
                base = (j_reg == '0) ? '0 : acc_reg;
            end
            ST_CROSS:
            begin
                case (ji)
                    2'd0:
                    begin
                        ma = j_reg[0] ? MUL_W'(nk[2]) : MUL_W'(nk[1]);
                        mb = j_reg[0] ? MUL_W'(tq_reg[1]) : MUL_W'(tq_reg[2]);
                    end
                    2'd1:
                    begin
                        ma = j_reg[0] ? MUL_W'(nk[0]) : MUL_W'(nk[2]);
                        mb = j_reg[0] ? MUL_W'(tq_reg[2]) : MUL_W'(tq_reg[0]);
                    end
                    default:
                    begin
                        ma = j_reg[0] ? MUL_W'(nk[1]) : MUL_W'(nk[0]);
                        mb = j_reg[0] ? MUL_W'(tq_reg[0]) : MUL_W'(tq_reg[1]);
                    end
                endcase
                if (!j_reg[0])
                begin
                    base = '0;
                end
                else
                begin
                    sub = 1'b1;
                end
            end
            ST_HAND:
            begin
                ma   = MUL_W'(c_reg[j_reg[1:0]]);
                mb   = MUL_W'(b_reg[j_reg[1:0]]);
                base = (j_reg == '0) ? '0 : acc_reg;
            end
            default:
            begin
                base = acc_reg;
            end
        endcase
    end

    assign sp       = shf ? (prod_reg <<< D_SPLIT) : prod_reg;
    assign acc_next = sub ? (base - sp) : (base + sp);

    // Block scaling: one step of a power-of-two shift on the working vector.
    always_comb
    begin
        logic [ACC_W-1:0] m;
        m = '0;
        for (int i = 0; i < 3; i++)
        begin
            wm[i] = w_reg[i][ACC_W-1] ? unsigned'(-w_reg[i]) : unsigned'(w_reg[i]);
        end
        mx = wm[0];
        if (wm[1] > mx)
        begin
            mx = wm[1];
        end
        if (wm[2] > mx)
        begin
            mx = wm[2];
        end
        up     = (nsel_reg != NS_T);
        big1   = up ? (mx >= (ACC_W'(1) << SB_HI)) : (mx >= (ACC_W'(1) << T_HI));
        big8   = up ? (mx >= (ACC_W'(1) << (SB_HI + COARSE)))
                    : (mx >= (ACC_W'(1) << (T_HI + COARSE)));
        small1 = up && (mx != '0) && (mx < (ACC_W'(1) << SB_LO));
        small8 = up && (mx != '0) && (mx < (ACC_W'(1) << (SB_LO - COARSE)));
        norm_done = !big1 && !small1;
        for (int i = 0; i < 3; i++)
        begin
            if (big1)
            begin
                m     = big8 ? (wm[i] >> COARSE) : (wm[i] >> 1);
                wn[i] = w_reg[i][ACC_W-1] ? -signed'(m) : signed'(m);
            end
            else if (small1)
            begin
                wn[i] = small8 ? (w_reg[i] <<< COARSE) : (w_reg[i] <<< 1);
            end
            else
            begin
                wn[i] = w_reg[i];
            end
        end
    end

    // Square root step, division step and quotient rounding.
    assign rb    = r_reg + bit_reg;
    assign sq_ge = (x_reg >= rb);
    assign trial = {1'b0, num_reg} - {1'b0, dsh_reg};
    assign dv_ge = !trial[NUM_W];
    assign q_next = {q_reg[QUOT_W-2:0], dv_ge};
    assign qc     = (q_next > Q_MAX) ? Q_MAX : q_next;
    assign tq_next = w_reg[i_reg][ACC_W-1] ? -signed'(NORM_W'(qc)) : signed'(NORM_W'(qc));

    // Degenerate texture mapping check.
    always_comb
    begin
        logic [ACC_W-1:0] am;
        am = acc_reg[ACC_W-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
        det_small = (am <= ACC_W'(min_uv_area));
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (st_reg == ST_EMIT) && out_free && (k_reg == K_LAST);
    assign out_valid = out_valid_reg;
    assign tan_x     = tan_reg[0];
    assign tan_y     = tan_reg[1];
    assign tan_z     = tan_reg[2];
    assign mirrored  = mir_reg;
    assign last_corner = last_reg;

    // Multiplier product register.
    always_ff @(posedge clk)
    begin
        if (!ph_reg)
        begin
            prod_reg <= ma * mb;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            ph_reg        <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            nsel_reg      <= NS_S;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    ph_reg <= 1'b0;
                    j_reg  <= '0;
                    if (q_valid)
                    begin
                        st_reg <= ST_DET;
                    end
                end
                ST_DET:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_DET_LAST)
                        begin
                            st_reg <= ST_SIGN;
                        end
                    end
                end
                ST_SIGN:
                begin
                    j_reg    <= '0;
                    nsel_reg <= NS_S;
                    st_reg   <= ST_SB;
                end
                ST_SB:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_PAIR_LAST)
                        begin
                            st_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (norm_done)
                    begin
                        j_reg <= '0;
                        case (nsel_reg)
                            NS_S:
                            begin
                                nsel_reg <= NS_B;
                                st_reg   <= ST_SB;
                            end
                            NS_B:
                            begin
                                k_reg  <= '0;
                                st_reg <= ST_DOT;
                            end
                            default:
                            begin
                                st_reg <= ST_LEN;
                            end
                        endcase
                    end
                end
                ST_DOT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_TRI_LAST)
                        begin
                            j_reg  <= '0;
                            st_reg <= ST_TVEC;
                        end
                    end
                end
                ST_TVEC:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_PAIR_LAST)
                        begin
                            st_reg <= ST_TCHK;
                        end
                    end
                end
                ST_TCHK:
                begin
                    j_reg <= '0;
                    if ((w_reg[0] == '0) && (w_reg[1] == '0) && (w_reg[2] == '0))
                    begin
                        st_reg <= ST_CROSS;
                    end
                    else
                    begin
                        nsel_reg <= NS_T;
                        st_reg   <= ST_NORM;
                    end
                end
                ST_LEN:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_TRI_LAST)
                        begin
                            st_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT:
                begin
                    if (bit_reg == ACC_W'(1))
                    begin
                        i_reg  <= '0;
                        st_reg <= ST_DINIT;
                    end
                end
                ST_DINIT:
                begin
                    dcnt_reg <= '0;
                    st_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 4'd1;
                    if (dcnt_reg == 4'(QUOT_W - 1))
                    begin
                        if (i_reg == K_LAST)
                        begin
                            j_reg  <= '0;
                            st_reg <= ST_CROSS;
                        end
                        else
                        begin
                            i_reg  <= i_reg + 2'd1;
                            st_reg <= ST_DINIT;
                        end
                    end
                end
                ST_CROSS:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_PAIR_LAST)
                        begin
                            j_reg  <= '0;
                            st_reg <= ST_HAND;
                        end
                    end
                end
                ST_HAND:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        if (j_reg == J_TRI_LAST)
                        begin
                            st_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        j_reg         <= '0;
                        if (k_reg == K_LAST)
                        begin
                            st_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg  <= k_reg + 2'd1;
                            st_reg <= ST_DOT;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Data path updates.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_DET, ST_DOT, ST_HAND:
            begin
                if (ph_reg)
                begin
                    acc_reg <= acc_next;
                end
                if (ph_reg && (st_reg == ST_DOT) && (j_reg == J_TRI_LAST))
                begin
                    d_reg <= acc_next[DOT_W-1:0];
                end
                if (ph_reg && (st_reg == ST_HAND) && (j_reg == J_TRI_LAST))
                begin
                    mir_reg <= acc_next[ACC_W-1];
                end
            end
            ST_SIGN:
            begin
                sg_zero_reg <= det_small;
                sg_neg_reg  <= acc_reg[ACC_W-1];
            end
            ST_SB, ST_TVEC:
            begin
                if (ph_reg)
                begin
                    acc_reg <= acc_next;
                    if (j_reg[0])
                    begin
                        if ((st_reg == ST_SB) && sg_zero_reg)
                        begin
                            w_reg[ji] <= '0;
                        end
                        else
                        begin
                            w_reg[ji] <= acc_next;
                        end
                    end
                end
            end
            ST_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_reg[i] <= wn[i];
                end
                if (norm_done && (nsel_reg == NS_S))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        s_reg[i] <= w_reg[i][SB_W-1:0];
                    end
                end
                if (norm_done && (nsel_reg == NS_B))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        b_reg[i] <= w_reg[i][SB_W-1:0];
                    end
                end
            end
            ST_TCHK:
            begin
                // A vanished tangent falls back to the x axis.
                tq_reg[0] <= NORM_W'(ONE_Q14);
                tq_reg[1] <= '0;
                tq_reg[2] <= '0;
            end
            ST_LEN:
            begin
                if (ph_reg)
                begin
                    acc_reg <= acc_next;
                    if (j_reg == J_TRI_LAST)
                    begin
                        x_reg   <= unsigned'(acc_next);
                        r_reg   <= '0;
                        bit_reg <= ACC_W'(1) << SQRT_TOP;
                    end
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    x_reg <= x_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == ACC_W'(1))
                begin
                    l_reg <= sq_ge ? LEN_W'((r_reg >> 1) + bit_reg) : LEN_W'(r_reg >> 1);
                end
            end
            ST_DINIT:
            begin
                num_reg <= (NUM_W'(wm[i_reg][T_HI-1:0]) << Q_SHIFT) + NUM_W'(l_reg);
                dsh_reg <= NUM_W'(l_reg) << QUOT_W;
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                if (dv_ge)
                begin
                    num_reg <= trial[NUM_W-1:0];
                end
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_next;
                if (dcnt_reg == 4'(QUOT_W - 1))
                begin
                    tq_reg[i_reg] <= tq_next;
                end
            end
            ST_CROSS:
            begin
                if (ph_reg)
                begin
                    acc_reg <= acc_next;
                    if (j_reg[0])
                    begin
                        c_reg[ji] <= acc_next[CROSS_W-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        tan_reg[i] <= VALUE_WIDTH'(tq_reg[i]);
                    end
                    last_reg <= (k_reg == K_LAST);
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

// ----- rtl/triangle_tangent_frame.sv -----
// Each triangle yields three results, one per corner, once its third corner item
// is taken; the back end works through them with its single shared multiplier
// and its bit-serial square root and divider.
// The first two corner items of a triangle are always taken; the third waits
// for a free slot of the two-entry triangle queue.
// Reset (rst_n low, asynchronous) empties the queue and clears min_uv_area to zero.
module triangle_tangent_frame
    import ttf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] pos_x,
    input  logic signed [VALUE_WIDTH-1:0] pos_y,
    input  logic signed [VALUE_WIDTH-1:0] pos_z,
    input  logic signed [VALUE_WIDTH-1:0] norm_x,
    input  logic signed [VALUE_WIDTH-1:0] norm_y,
    input  logic signed [VALUE_WIDTH-1:0] norm_z,
    input  logic signed [VALUE_WIDTH-1:0] tex_u,
    input  logic signed [VALUE_WIDTH-1:0] tex_v,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] tan_x,
    output logic signed [VALUE_WIDTH-1:0] tan_y,
    output logic signed [VALUE_WIDTH-1:0] tan_z,
    output logic                          mirrored,
    output logic                          last_corner,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data
);

    localparam int REC_W = rec_width(VALUE_WIDTH);

    logic [CFG_W-1:0] min_uv_area_reg;
    logic             q_push, q_full, q_pop, q_valid;
    logic [REC_W-1:0] push_rec, head_rec;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_uv_area_reg <= '0;
        end
        else if (cfg_valid)
        begin
            min_uv_area_reg <= cfg_data;
        end
    end

    // Corner intake and triangle assembly.
    ttf_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .norm_x   (norm_x),
        .norm_y   (norm_y),
        .norm_z   (norm_z),
        .tex_u    (tex_u),
        .tex_v    (tex_v),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_rec)
    );

    // Triangle queue.
    ttf_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_rec)
    );

    // Tangent computation and result register.
    ttf_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_uv_area (min_uv_area_reg),
        .q_valid     (q_valid),
        .q_data      (head_rec),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tan_x       (tan_x),
        .tan_y       (tan_y),
        .tan_z       (tan_z),
        .mirrored    (mirrored),
        .last_corner (last_corner)
    );

endmodule

// ----- dv/tb_triangle_tangent_frame.sv -----
module tb_triangle_tangent_frame;
    import ttf_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 600;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [VW-1:0] tan_x;
        logic signed [VW-1:0] tan_y;
        logic signed [VW-1:0] tan_z;
        logic                 mirrored;
        logic                 last_corner;
    } tangent_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [VW-1:0] pos_x, pos_y, pos_z;
    logic signed [VW-1:0] norm_x, norm_y, norm_z;
    logic signed [VW-1:0] tex_u, tex_v;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [VW-1:0] tan_x, tan_y, tan_z;
    logic                 mirrored;
    logic                 last_corner;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    // Predictor state: threshold, corner count and the two held corners.
    logic [CFG_W-1:0] uv_area_limit;
    int               corners_held;
    longint           held_pos [2][3];
    longint           held_norm [2][3];
    longint           held_uv [2][2];

    tangent_t expected_tangents [$];
    int       fail_count;
    bit       calm;

    triangle_tangent_frame DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .out_valid(out_valid), .out_ready(out_ready),
        .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
        .mirrored(mirrored), .last_corner(last_corner),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint abs64(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint clamp_q14(input longint x);
        if (x > ONE_Q14) return ONE_Q14;
        if (x < -ONE_Q14) return -ONE_Q14;
        return x;
    endfunction

    // Shift a vector as one block, on magnitudes, until its peak is in range.
    function automatic void scale_block(inout vec3_t v, input int hi, input int lo,
                                        input bit up);
        longint m [3];
        longint mx;
        bit     neg [3];
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            m[i] = abs64(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return;
        while (mx >= (64'sd1 <<< hi))
        begin
            mx = mx >>> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
        end
        while (up && mx < (64'sd1 <<< lo))
        begin
            mx = mx <<< 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
        end
        for (int i = 0; i < 3; i++) v[i] = neg[i] ? -m[i] : m[i];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Gram-Schmidt of the triangle tangent against one corner normal.
    function automatic tangent_t corner_tangent(input vec3_t n, input vec3_t s,
                                                input vec3_t b, input bit lastc);
        vec3_t           t;
        longint          tq [3];
        longint          d, c0, c1, c2, h;
        longint unsigned len2, len, q;
        tangent_t        r;
        d = n[0] * s[0] + n[1] * s[1] + n[2] * s[2];
        for (int i = 0; i < 3; i++) t[i] = s[i] * (64'sd1 <<< 28) - n[i] * d;
        if (t[0] == 0 && t[1] == 0 && t[2] == 0)
        begin
            tq[0] = ONE_Q14;
            tq[1] = 0;
            tq[2] = 0;
        end
        else
        begin
            scale_block(t, T_HI, 0, 1'b0);
            len2 = 0;
            for (int i = 0; i < 3; i++) len2 += abs64(t[i]) * abs64(t[i]);
            len = int_sqrt(len2);
            for (int i = 0; i < 3; i++)
            begin
                q = (longint'(abs64(t[i])) * 32768 + len) / (2 * len);
                if (q > ONE_Q14) q = ONE_Q14;
                tq[i] = (t[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
        // Handedness from the emitted tangent.
        c0 = n[1] * tq[2] - n[2] * tq[1];
        c1 = n[2] * tq[0] - n[0] * tq[2];
        c2 = n[0] * tq[1] - n[1] * tq[0];
        h = c0 * b[0] + c1 * b[1] + c2 * b[2];
        r.tan_x = tq[0][VW-1:0];
        r.tan_y = tq[1][VW-1:0];
        r.tan_z = tq[2][VW-1:0];
        r.mirrored = h < 0;
        r.last_corner = lastc;
        return r;
    endfunction

    // Hold the first two corners; the third one yields three tangents.
    function automatic void predict_corner(input longint p [3], input longint nr [3],
                                           input longint uv [2]);
        longint n [3];
        vec3_t  s, b, nk;
        longint du1, dv1, du2, dv2, det, sg, e1, e2;
        for (int i = 0; i < 3; i++) n[i] = clamp_q14(nr[i]);
        if (corners_held < 2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_pos[corners_held][i] = p[i];
                held_norm[corners_held][i] = n[i];
            end
            held_uv[corners_held][0] = uv[0];
            held_uv[corners_held][1] = uv[1];
            corners_held++;
            return;
        end
        corners_held = 0;
        du1 = held_uv[1][0] - held_uv[0][0];
        dv1 = held_uv[1][1] - held_uv[0][1];
        du2 = uv[0] - held_uv[0][0];
        dv2 = uv[1] - held_uv[0][1];
        det = du1 * dv2 - du2 * dv1;
        if (abs64(det) <= longint'(uv_area_limit)) sg = 0;
        else sg = (det < 0) ? -1 : 1;
        for (int i = 0; i < 3; i++)
        begin
            e1 = held_pos[1][i] - held_pos[0][i];
            e2 = p[i] - held_pos[0][i];
            s[i] = (dv2 * e1 - dv1 * e2) * sg;
            b[i] = (du1 * e2 - du2 * e1) * sg;
        end
        scale_block(s, SB_HI, SB_LO, 1'b1);
        scale_block(b, SB_HI, SB_LO, 1'b1);
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++) nk[i] = (k < 2) ? held_norm[k][i] : n[i];
            expected_tangents.push_back(corner_tangent(nk, s, b, k == 2));
        end
    endfunction

    // Send one corner item, with an occasional idle burst ahead of it.
    task automatic send_corner(input logic [VW-1:0] px, py, pz, nx, ny, nz, u, v);
        longint p [3];
        longint n [3];
        longint uv [2];
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        norm_x <= nx; norm_y <= ny; norm_z <= nz;
        tex_u <= u; tex_v <= v;
        do @(posedge clk); while (!in_ready);
        p[0] = longint'(signed'(px));
        p[1] = longint'(signed'(py));
        p[2] = longint'(signed'(pz));
        n[0] = longint'(signed'(nx));
        n[1] = longint'(signed'(ny));
        n[2] = longint'(signed'(nz));
        uv[0] = longint'(signed'(u));
        uv[1] = longint'(signed'(v));
        predict_corner(p, n, uv);
    endtask

    // Drain all tangents, let the back end settle, then write the threshold.
    task automatic set_uv_area_limit(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_tangents.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        uv_area_limit = value;
    endtask

    function automatic logic [VW-1:0] rand_normal(input bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 2 * ONE_Q14) - ONE_Q14;
    endfunction

    function automatic logic [VW-1:0] rand_small(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic test_directed();
        // Extremes of positions and texture coordinates, zero threshold.
        send_corner(16'h8000, 16'h8000, 16'h8000, 0, 0, ONE_Q14, 16'h8000, 16'h8000);
        send_corner(16'h7fff, 16'h8000, 16'h7fff, 0, 0, ONE_Q14, 16'h7fff, 16'h8000);
        send_corner(16'h8000, 16'h7fff, 16'h7fff, 0, 0, ONE_Q14, 16'h8000, 16'h7fff);
        // Plain triangle in the xy plane, then the same with v mirrored.
        send_corner(0, 0, 0, 0, 0, ONE_Q14, 0, 0);
        send_corner(256, 0, 0, 0, 0, ONE_Q14, 4096, 0);
        send_corner(0, 256, 0, 0, 0, ONE_Q14, 0, 4096);
        send_corner(0, 0, 0, 0, 0, ONE_Q14, 0, 0);
        send_corner(256, 0, 0, 0, 0, ONE_Q14, 4096, 0);
        send_corner(0, 256, 0, 0, 0, ONE_Q14, 0, -4096);
        // Degenerate texture coordinates: all corners share one UV.
        send_corner(0, 0, 0, 0, ONE_Q14, 0, 100, 100);
        send_corner(300, 0, 0, 0, ONE_Q14, 0, 100, 100);
        send_corner(0, 0, 300, 0, ONE_Q14, 0, 100, 100);
        // Normal along the tangent, so the projected tangent vanishes.
        send_corner(0, 0, 0, ONE_Q14, 0, 0, 0, 0);
        send_corner(256, 0, 0, -ONE_Q14, 0, 0, 4096, 0);
        send_corner(0, 256, 0, ONE_Q14, 0, 0, 0, 4096);
        // Normals outside the unit range get saturated.
        send_corner(10, 20, 30, 16'h7fff, 16'h8000, 16'h4001, 16'h7fff, 0);
        send_corner(500, -40, 7, 16'h8000, 16'h7fff, 16'hbfff, 0, 16'h7fff);
        send_corner(-90, 600, 1, 16'h4001, 16'hbfff, 16'h7fff, 16'h8000, 16'h8000);
    endtask

    task automatic test_threshold_extremes();
        // Largest threshold: small-area UV triangles fall to zero gradient.
        set_uv_area_limit(16'hffff);
        for (int t = 0; t < 8; t++)
            for (int c = 0; c < 3; c++)
                send_corner(rand_small(2000), rand_small(2000), rand_small(2000),
                            rand_normal(0), rand_normal(0), rand_normal(0),
                            rand_small(t < 4 ? 200 : 30000),
                            rand_small(t < 4 ? 200 : 30000));
        // Smallest nonzero threshold.
        set_uv_area_limit(16'd1);
        for (int c = 0; c < 3; c++)
            send_corner(rand_small(100), rand_small(100), rand_small(100),
                        rand_normal(0), rand_normal(0), rand_normal(0),
                        rand_small(1), rand_small(1));
    endtask

    task automatic test_random_triangles(input int count, input int uv_span);
        bit wide;
        for (int t = 0; t < count; t++)
        begin
            wide = $urandom_range(0, 7) == 0;
            for (int c = 0; c < 3; c++)
                send_corner(wide ? $urandom : rand_small(4000),
                            wide ? $urandom : rand_small(4000),
                            wide ? $urandom : rand_small(4000),
                            rand_normal(wide), rand_normal(wide), rand_normal(wide),
                            wide ? $urandom : rand_small(uv_span),
                            wide ? $urandom : rand_small(uv_span));
        end
    endtask

    // Compare each accepted tangent with the oldest prediction.
    always @(posedge clk)
    begin
        tangent_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tangents.size() == 0)
            begin
                $error("unexpected tangent %0d %0d %0d", tan_x, tan_y, tan_z);
                fail_count++;
            end
            else
            begin
                e = expected_tangents.pop_front();
                if (tan_x !== e.tan_x)
                begin
                    $error("tan_x expected %0d got %0d", e.tan_x, tan_x);
                    fail_count++;
                end
                if (tan_y !== e.tan_y)
                begin
                    $error("tan_y expected %0d got %0d", e.tan_y, tan_y);
                    fail_count++;
                end
                if (tan_z !== e.tan_z)
                begin
                    $error("tan_z expected %0d got %0d", e.tan_z, tan_z);
                    fail_count++;
                end
                if (mirrored !== e.mirrored)
                begin
                    $error("mirrored expected %0d got %0d", e.mirrored, mirrored);
                    fail_count++;
                end
                if (last_corner !== e.last_corner)
                begin
                    $error("last_corner expected %0d got %0d", e.last_corner, last_corner);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls in random bursts, none once the run is calm.
    always @(posedge clk)
    begin
        int stall;
        if (!calm && stall == 0 && $urandom_range(0, 5) == 0)
            stall = $urandom_range(1, 11);
        if (stall > 0)
        begin
            out_ready <= 1'b0;
            stall--;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v} = '0;
        uv_area_limit = '0;
        corners_held = 0;
        fail_count = 0;
        calm = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        set_uv_area_limit(16'd0);
        test_random_triangles(35, 30000);
        set_uv_area_limit($urandom);
        test_random_triangles(25, 600);
        set_uv_area_limit(16'd0);
        calm = 1'b1;
        test_random_triangles(25, 30000);

        in_valid <= 1'b0;
        while (expected_tangents.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
